// ----- rtl/core/aosd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// aosd_pkg: shared types and constants
// Widths, class codes and controller-to-datapath command types.
// ----------------------------------------------------------------------------
package aosd_pkg;

	localparam int SampleBits = 16;
	localparam int TimeBits   = 48;
	localparam int SmoothBits = SampleBits + 12;
	localparam int CfgIdxBits = 3;
	localparam int CfgDataBits = 24;

	localparam logic [11:0] GravityQ8 = 12'd2510;
	localparam logic [12:0] TiltSqQ12 = 13'd5417;

	// Register indexes.
	localparam logic [CfgIdxBits-1:0] RegAlpha    = 3'd0;
	localparam logic [CfgIdxBits-1:0] RegOrientMin = 3'd1;
	localparam logic [CfgIdxBits-1:0] RegStable   = 3'd2;
	localparam logic [CfgIdxBits-1:0] RegJerkLow  = 3'd3;
	localparam logic [CfgIdxBits-1:0] RegJerkHigh = 3'd4;
	localparam logic [CfgIdxBits-1:0] RegGravBand = 3'd5;
	localparam logic [CfgIdxBits-1:0] RegCooldown = 3'd6;

	// Orientation class codes.
	localparam logic [2:0] Orient0   = 3'd0;
	localparam logic [2:0] Orient90  = 3'd1;
	localparam logic [2:0] Orient180 = 3'd2;
	localparam logic [2:0] Orient270 = 3'd3;
	localparam logic [2:0] ClassNone = 3'd4;

	// Datapath operation steps.
	typedef enum logic [2:0] {
		OP_LOAD,
		OP_FILT_X,
		OP_FILT_Y,
		OP_FILT_Z,
		OP_SQUARES,
		OP_CLASSIFY,
		OP_DECIDE
	} aosd_op_t;

	typedef struct packed {
		logic      run;
		aosd_op_t  op;
	} aosd_cmd_t;

endpackage
`default_nettype wire

// ----- rtl/core/aosd_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// aosd_datapath: filter, classifier and shake scoring
// Executes one step per command; holds all filter and detector state.
// ----------------------------------------------------------------------------
module aosd_datapath (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire aosd_pkg::aosd_cmd_t                 cmd,
	input  wire logic signed [aosd_pkg::SampleBits-1:0] in_x,
	input  wire logic signed [aosd_pkg::SampleBits-1:0] in_y,
	input  wire logic signed [aosd_pkg::SampleBits-1:0] in_z,
	input  wire logic [aosd_pkg::TimeBits-1:0]       in_t,
	input  wire logic                                cfg_we,
	input  wire logic [aosd_pkg::CfgIdxBits-1:0]     cfg_idx,
	input  wire logic [aosd_pkg::CfgDataBits-1:0]    cfg_data,
	output logic                                     res_changed,
	output logic [1:0]                               res_orient,
	output logic                                     res_known,
	output logic                                     res_shake
);
	import aosd_pkg::*;

	localparam int SB = SampleBits;
	localparam int SqB = 2 * SB + 2;

	// Configuration registers.
	logic [11:0] alpha_q;
	logic [14:0] omin_q;
	logic [3:0]  stable_q;
	logic [15:0] jlow_q, jhigh_q;
	logic [14:0] band_q;
	logic [23:0] cool_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q  <= 12'd901;
			omin_q   <= 15'd1485;
			stable_q <= 4'd5;
			jlow_q   <= 16'd1280;
			jhigh_q  <= 16'd2304;
			band_q   <= 15'd717;
			cool_q   <= 24'd2000000;
		end else if (cfg_we) begin
			case (cfg_idx)
				RegAlpha:     alpha_q  <= cfg_data[11:0];
				RegOrientMin: omin_q   <= cfg_data[14:0];
				RegStable:    stable_q <= cfg_data[3:0];
				RegJerkLow:   jlow_q   <= cfg_data[15:0];
				RegJerkHigh:  jhigh_q  <= cfg_data[15:0];
				RegGravBand:  band_q   <= cfg_data[14:0];
				RegCooldown:  cool_q   <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// Detector state.
	logic                         primed_q;
	logic signed [SmoothBits-1:0] sx_q, sy_q, sz_q;
	logic signed [SB-1:0]         lx_q, ly_q, lz_q;
	logic [2:0]                   cand_q, appl_q;
	logic [3:0]                   run_q;
	logic [1:0]                   score_q;
	logic [TimeBits-1:0]          lshake_q;
	// Work registers for the squared terms.
	logic [SqB-1:0]               m2_q, j2_q;
	logic [SqB-1:0]               plane_q;
	logic [SqB+13:0]              zsq_q, plane_k_q;
	logic [SB:0]                  axm_q, aym_q;
	logic                         xpos_q, ypos_q;

	// Filter step: one axis per cycle through one multiplier.
	logic signed [SmoothBits-1:0] f_cur;
	logic signed [SB-1:0]         f_smp;
	logic signed [SmoothBits:0]   f_diff;
	logic signed [SmoothBits+13:0] f_prod;
	logic signed [SmoothBits-1:0] f_new;

	always_comb begin
		case (cmd.op)
			OP_FILT_Y: begin f_cur = sy_q; f_smp = in_y; end
			OP_FILT_Z: begin f_cur = sz_q; f_smp = in_z; end
			default:   begin f_cur = sx_q; f_smp = in_x; end
		endcase
		f_diff = $signed({f_smp, 12'd0}) - f_cur;
		f_prod = f_diff * $signed({1'b0, alpha_q});
		// Arithmetic shift gives floor division by 4096.
		f_new  = f_cur + SmoothBits'(f_prod >>> 12);
	end

	// Smoothed values in Q8.8 by floor.
	logic signed [SB-1:0] qx, qy, qz;
	assign qx = sx_q[SmoothBits-1:12];
	assign qy = sy_q[SmoothBits-1:12];
	assign qz = sz_q[SmoothBits-1:12];

	function automatic logic [SB:0] absv(input logic signed [SB:0] v);
		absv = v[SB] ? SB'(0) - v : v;
	endfunction

	logic [SB:0] ax, ay, az, djx, djy, djz, sqx, sqy, sqz;
	always_comb begin
		ax  = absv({in_x[SB-1], in_x});
		ay  = absv({in_y[SB-1], in_y});
		az  = absv({in_z[SB-1], in_z});
		djx = absv({in_x[SB-1], in_x} - {lx_q[SB-1], lx_q});
		djy = absv({in_y[SB-1], in_y} - {ly_q[SB-1], ly_q});
		djz = absv({in_z[SB-1], in_z} - {lz_q[SB-1], lz_q});
		sqx = absv({qx[SB-1], qx});
		sqy = absv({qy[SB-1], qy});
		sqz = absv({qz[SB-1], qz});
	end

	// Classification from registered squares.
	logic [2:0]  cls;
	logic [29:0] omin_sq;
	always_comb begin
		omin_sq = omin_q * omin_q;
		if (plane_q < SqB'(omin_sq) || zsq_q > plane_k_q)
			cls = ClassNone;
		else if (axm_q > aym_q)
			cls = xpos_q ? Orient270 : Orient90;
		else
			cls = ypos_q ? Orient0 : Orient180;
	end

	// Shake decision.
	logic [15:0] hi, lo;
	logic [31:0] hi_sq, lo_sq, jl_sq, jh_sq;
	logic        dev, peak, cool_ok;
	logic [1:0]  score_nx;
	logic [TimeBits-1:0] elapsed;
	always_comb begin
		hi    = 16'(GravityQ8) + 16'(band_q);
		lo    = 16'(GravityQ8) - 16'(band_q);
		hi_sq = hi * hi;
		lo_sq = lo * lo;
		jl_sq = jlow_q * jlow_q;
		jh_sq = jhigh_q * jhigh_q;
		dev   = (m2_q > SqB'(hi_sq)) ||
			((band_q < 15'(GravityQ8)) && (m2_q < SqB'(lo_sq)));
		peak  = ((j2_q > SqB'(jl_sq)) && dev) || (j2_q > SqB'(jh_sq));
		if (peak)
			score_nx = (score_q == 2'd3) ? score_q : score_q + 2'd1;
		else
			score_nx = (score_q == 2'd0) ? score_q : score_q - 2'd1;
		elapsed = in_t - lshake_q;
		cool_ok = elapsed >= TimeBits'(cool_q);
	end

	logic [3:0] run_nx;
	logic [2:0] cand_nx;
	always_comb begin
		if (cls == cand_q) begin
			cand_nx = cand_q;
			run_nx  = (run_q == 4'd15) ? run_q : run_q + 4'd1;
		end else begin
			cand_nx = cls;
			run_nx  = 4'd1;
		end
	end

	// Step execution.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q    <= 1'b0;
			sx_q        <= '0;
			sy_q        <= '0;
			sz_q        <= '0;
			lx_q        <= '0;
			ly_q        <= '0;
			lz_q        <= '0;
			cand_q      <= ClassNone;
			appl_q      <= ClassNone;
			run_q       <= '0;
			score_q     <= '0;
			lshake_q    <= '0;
			res_changed <= 1'b0;
			res_shake   <= 1'b0;
		end else if (cmd.run) begin
			case (cmd.op)
				OP_LOAD: begin
					res_changed <= 1'b0;
					res_shake   <= 1'b0;
					if (!primed_q) begin
						sx_q     <= {in_x, 12'd0};
						sy_q     <= {in_y, 12'd0};
						sz_q     <= {in_z, 12'd0};
						lx_q     <= in_x;
						ly_q     <= in_y;
						lz_q     <= in_z;
						primed_q <= 1'b1;
					end
				end
				OP_FILT_X: if (primed_q) sx_q <= f_new;
				OP_FILT_Y: sy_q <= f_new;
				OP_FILT_Z: sz_q <= f_new;
				OP_CLASSIFY: begin
					if (cls != ClassNone) begin
						cand_q <= cand_nx;
						run_q  <= run_nx;
						if (run_nx >= stable_q && cls != appl_q) begin
							appl_q      <= cls;
							res_changed <= 1'b1;
						end
					end
				end
				OP_DECIDE: begin
					if (score_nx >= 2'd2 && cool_ok) begin
						lshake_q  <= in_t;
						score_q   <= '0;
						res_shake <= 1'b1;
					end else begin
						score_q <= score_nx;
					end
					lx_q <= in_x;
					ly_q <= in_y;
					lz_q <= in_z;
				end
				default: ;
			endcase
		end
	end

	// Square terms, registered before compare.
	always_ff @(posedge clk) begin
		if (cmd.run && cmd.op == OP_SQUARES) begin
			m2_q      <= SqB'(ax * ax) + SqB'(ay * ay) + SqB'(az * az);
			j2_q      <= SqB'(djx * djx) + SqB'(djy * djy) + SqB'(djz * djz);
			plane_q   <= SqB'(sqx * sqx) + SqB'(sqy * sqy);
			plane_k_q <= (SqB+14)'(SqB'(sqx * sqx) + SqB'(sqy * sqy)) * TiltSqQ12;
			zsq_q     <= (SqB+14)'({SqB'(sqz * sqz), 12'd0});
			axm_q     <= sqx;
			aym_q     <= sqy;
			xpos_q    <= !qx[SB-1] && (qx != '0);
			ypos_q    <= !qy[SB-1] && (qy != '0);
		end
	end

	assign res_orient = (appl_q == ClassNone) ? 2'd0 : appl_q[1:0];
	assign res_known  = (appl_q != ClassNone);

endmodule
`default_nettype wire

// ----- rtl/core/aosd_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// aosd_ctrl: sequencer
// Steps the datapath through one sample and holds the result beat.
// ----------------------------------------------------------------------------
module aosd_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output aosd_pkg::aosd_cmd_t    cmd,
	output logic                   capture
);
	import aosd_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_WORK, ST_DONE} state_t;

	state_t   state_q;
	aosd_op_t op_q;

	// Input is taken when idle and no result is pending.
	assign in_ready = (state_q == ST_IDLE) && !out_valid;
	assign capture  = in_valid && in_ready;
	assign cmd.run  = (state_q == ST_WORK);
	assign cmd.op   = op_q;

	// Sequencer and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			op_q      <= OP_LOAD;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: if (capture) begin
					state_q <= ST_WORK;
					op_q    <= OP_LOAD;
				end
				ST_WORK: begin
					if (op_q == OP_DECIDE)
						state_q <= ST_DONE;
					else
						op_q <= aosd_op_t'(op_q + 3'd1);
				end
				ST_DONE: begin
					out_valid <= 1'b1;
					state_q   <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/accel_orientation_shake_detector_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// accel_orientation_shake_detector_unit: orientation and shake detector
// Low-pass filtered orientation classifier and jerk-based shake scorer.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one beat per sample: accel_x/y/z (Q8.8) and
//   time_us. The output channel returns one beat per sample with
//   orientation_changed, orientation, orientation_known and shake_detected.
//   Configuration registers are written through the cfg channel (index,
//   data); the user must write them only while the block is idle, which the
//   block itself does not enforce; cfg_ready is always high. After an input
//   beat is taken, a sequencer walks one load step, three filter steps sharing
//   one multiplier, a square step, a classify step and a decide step, and then
//   raises out_valid. The input is held in a register for the whole sequence.
//   A new sample is taken only once the previous result beat has been
//   accepted, so a stalled receiver stalls the input.
//   Reset clears all detector state and loads register defaults; the first
//   sample after reset seeds the filter.
// ----------------------------------------------------------------------------
module accel_orientation_shake_detector_unit (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic signed [aosd_pkg::SampleBits-1:0] accel_x,
	input  wire logic signed [aosd_pkg::SampleBits-1:0] accel_y,
	input  wire logic signed [aosd_pkg::SampleBits-1:0] accel_z,
	input  wire logic [aosd_pkg::TimeBits-1:0]         time_us,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic                                       orientation_changed,
	output logic [1:0]                                 orientation,
	output logic                                       orientation_known,
	output logic                                       shake_detected,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [aosd_pkg::CfgIdxBits-1:0]       cfg_index,
	input  wire logic [aosd_pkg::CfgDataBits-1:0]      cfg_data
);
	import aosd_pkg::*;

	aosd_cmd_t cmd;
	logic      capture;
	logic signed [SampleBits-1:0] x_q, y_q, z_q;
	logic [TimeBits-1:0]          t_q;

	assign cfg_ready = 1'b1;

	// Sample holding register.
	always_ff @(posedge clk) begin
		if (capture) begin
			x_q <= accel_x;
			y_q <= accel_y;
			z_q <= accel_z;
			t_q <= time_us;
		end
	end

	aosd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.capture   (capture)
	);

	aosd_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.in_x        (x_q),
		.in_y        (y_q),
		.in_z        (z_q),
		.in_t        (t_q),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_idx     (cfg_index),
		.cfg_data    (cfg_data),
		.res_changed (orientation_changed),
		.res_orient  (orientation),
		.res_known   (orientation_known),
		.res_shake   (shake_detected)
	);

	// A result beat is never offered while a sample is being taken.
	assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> !in_ready)
		else $error("input ready while result pending");
	// An unknown orientation always reads as zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		!orientation_known |-> orientation == 2'd0)
		else $error("orientation nonzero while unknown");
	// A change implies a known orientation.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && orientation_changed) |-> orientation_known)
		else $error("change without known orientation");

endmodule
`default_nettype wire

// ----- dv/accel_orientation_shake_detector_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// accel_orientation_shake_detector_unit_tb: self-checking testbench
// Streams accelerometer samples through the detector under random input gaps
// and output stalls. A behavioral tracker of the filter, classifier and
// shake scorer predicts every result beat, which is then checked field by
// field. Register settings are changed between phases while the block idles.
// ----------------------------------------------------------------------------
module accel_orientation_shake_detector_unit_tb;
	import aosd_pkg::*;

	localparam int WatchdogLimit = 5000;
	localparam int HoldOffCycles = 600;
	localparam int HoldOffAt     = 300;
	localparam int RandomPhases  = 8;
	localparam int PhaseSamples  = 140;

	typedef struct {
		logic signed [SampleBits-1:0] x;
		logic signed [SampleBits-1:0] y;
		logic signed [SampleBits-1:0] z;
		logic [TimeBits-1:0]          t;
	} sample_t;

	typedef struct {
		logic       changed;
		logic [1:0] orient;
		logic       known;
		logic       shake;
	} report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [SampleBits-1:0] accel_x = '0;
	logic signed [SampleBits-1:0] accel_y = '0;
	logic signed [SampleBits-1:0] accel_z = '0;
	logic [TimeBits-1:0] time_us = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic orientation_changed;
	logic [1:0] orientation;
	logic orientation_known;
	logic shake_detected;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CfgIdxBits-1:0] cfg_index = '0;
	logic [CfgDataBits-1:0] cfg_data = '0;

	sample_t pending_samples[$];
	report_t expected_reports[$];
	sample_t cur_sample;
	int errors = 0;
	int hold_seen = 0;
	int cycle_count = 0;
	int in_gap = 0;
	int out_stall = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	bit hold_off = 1'b0;
	int quiet_cycles = 0;
	logic [TimeBits-1:0] t_now = 48'd100;

	// Tracker copy of the registers.
	longint alpha_q12, orient_min, stable_cnt, jerk_lo, jerk_hi, grav_band;
	logic [TimeBits-1:0] cooldown;

	// Tracker copy of the detector state.
	bit primed;
	longint smooth[3];
	longint prev_raw[3];
	logic [2:0] candidate, applied;
	int run_len, motion_score;
	logic [TimeBits-1:0] last_shake_t;

	accel_orientation_shake_detector_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z), .time_us(time_us),
		.out_valid(out_valid), .out_ready(out_ready),
		.orientation_changed(orientation_changed), .orientation(orientation),
		.orientation_known(orientation_known), .shake_detected(shake_detected),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Gap lengths: mostly short, a few long, none at all during burst windows.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if ((cycle_count / 2000) % 4 == 0) return 0;
		if (r < 50) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic longint sq(longint v);
		return v * v;
	endfunction

	// Filter, classify and score one sample, then queue the report it causes.
	task automatic track_orientation_and_shake(sample_t s);
		longint raw[3];
		longint fx, fy, fz, plane, m2, j2, hi, lo;
		logic [2:0] cls;
		logic [TimeBits-1:0] elapsed;
		bit dev, peak;
		report_t rep;
		raw[0] = longint'(s.x);
		raw[1] = longint'(s.y);
		raw[2] = longint'(s.z);
		if (!primed) begin
			for (int i = 0; i < 3; i++) begin
				smooth[i] = raw[i] * 4096;
				prev_raw[i] = raw[i];
			end
			primed = 1'b1;
		end else begin
			for (int i = 0; i < 3; i++)
				smooth[i] = smooth[i] + (((raw[i] * 4096 - smooth[i]) * alpha_q12) >>> 12);
		end
		fx = smooth[0] >>> 12;
		fy = smooth[1] >>> 12;
		fz = smooth[2] >>> 12;
		plane = sq(fx) + sq(fy);
		if (plane < orient_min * orient_min) cls = ClassNone;
		else if (sq(fz) * 4096 > plane * 5417) cls = ClassNone;
		else if (sq(fx) > sq(fy)) cls = (fx > 0) ? Orient270 : Orient90;
		else cls = (fy > 0) ? Orient0 : Orient180;
		rep.changed = 1'b0;
		if (cls != ClassNone) begin
			if (cls == candidate) begin
				if (run_len < 15) run_len++;
			end else begin
				candidate = cls;
				run_len = 1;
			end
			if (run_len >= stable_cnt && cls != applied) begin
				applied = cls;
				rep.changed = 1'b1;
			end
		end
		m2 = sq(raw[0]) + sq(raw[1]) + sq(raw[2]);
		j2 = sq(raw[0] - prev_raw[0]) + sq(raw[1] - prev_raw[1]) + sq(raw[2] - prev_raw[2]);
		hi = 2510 + grav_band;
		dev = m2 > hi * hi;
		if (grav_band < 2510) begin
			lo = 2510 - grav_band;
			if (m2 < lo * lo) dev = 1'b1;
		end
		peak = (j2 > jerk_lo * jerk_lo && dev) || j2 > jerk_hi * jerk_hi;
		if (peak) begin
			if (motion_score < 3) motion_score++;
		end else if (motion_score > 0) begin
			motion_score--;
		end
		elapsed = s.t - last_shake_t;
		rep.shake = 1'b0;
		if (motion_score >= 2 && elapsed >= cooldown) begin
			last_shake_t = s.t;
			motion_score = 0;
			rep.shake = 1'b1;
		end
		for (int i = 0; i < 3; i++) prev_raw[i] = raw[i];
		rep.orient = (applied == ClassNone) ? 2'd0 : applied[1:0];
		rep.known = (applied != ClassNone);
		expected_reports.push_back(rep);
	endtask

	task automatic report_mismatch(string what, longint got, longint want);
		errors++;
		if (errors <= 40)
			$display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
	endtask

	// Input driver: holds each beat until accepted, then inserts a gap.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) track_orientation_and_shake(cur_sample);
			if (!in_valid || in_ready) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (pending_samples.size() > 0) begin
					cur_sample = pending_samples.pop_front();
					accel_x <= cur_sample.x;
					accel_y <= cur_sample.y;
					accel_z <= cur_sample.z;
					time_us <= cur_sample.t;
					in_valid <= 1'b1;
					in_gap = pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, timed in cycles by its own process.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) hold_seen++;
			if (hold_left > 0) begin
				hold_left--;
			end else if (!hold_done && hold_seen >= HoldOffAt) begin
				hold_done = 1'b1;
				hold_left = HoldOffCycles;
			end
			hold_off <= (hold_left > 0);
		end
	end

	// Output monitor: checks each result beat and stalls the receiver.
	always @(posedge clk) begin
		report_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_reports.size() == 0) begin
					report_mismatch("unexpected result beat", 1, 0);
				end else begin
					want = expected_reports.pop_front();
					if (orientation_changed !== want.changed)
						report_mismatch("orientation_changed", orientation_changed, want.changed);
					if (orientation !== want.orient)
						report_mismatch("orientation", orientation, want.orient);
					if (orientation_known !== want.known)
						report_mismatch("orientation_known", orientation_known, want.known);
					if (shake_detected !== want.shake)
						report_mismatch("shake_detected", shake_detected, want.shake);
				end
			end
			if (hold_off) begin
				out_ready <= 1'b0;
			end else if (out_stall > 0) begin
				out_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				out_stall = pick_gap();
			end
		end
	end

	// Watchdog on cycles with no beat on any channel.
	always @(posedge clk) begin
		cycle_count++;
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WatchdogLimit) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			RegAlpha:     alpha_q12 = val[11:0];
			RegOrientMin: orient_min = val[14:0];
			RegStable:    stable_cnt = val[3:0];
			RegJerkLow:   jerk_lo = val[15:0];
			RegJerkHigh:  jerk_hi = val[15:0];
			RegGravBand:  grav_band = val[14:0];
			RegCooldown:  cooldown = TimeBits'(val);
			default: ;
		endcase
	endtask

	task automatic write_all(logic [23:0] a, logic [23:0] om, logic [23:0] st, logic [23:0] jl,
			logic [23:0] jh, logic [23:0] gb, logic [23:0] cd);
		write_reg(RegAlpha, a);
		write_reg(RegOrientMin, om);
		write_reg(RegStable, st);
		write_reg(RegJerkLow, jl);
		write_reg(RegJerkHigh, jh);
		write_reg(RegGravBand, gb);
		write_reg(RegCooldown, cd);
	endtask

	// Block until every queued sample has been answered, then let it settle.
	task automatic wait_idle();
		while (pending_samples.size() > 0 || in_valid || expected_reports.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic add_sample(int x, int y, int z);
		sample_t s;
		s.x = SampleBits'(x);
		s.y = SampleBits'(y);
		s.z = SampleBits'(z);
		s.t = t_now;
		pending_samples.push_back(s);
	endtask

	function automatic int jitter(int v, int amount);
		return v + $urandom_range(0, 2 * amount) - amount;
	endfunction

	// Well-formed sequences with random content, plus some noise.
	task automatic add_random_sequence();
		int kind, n, mag, axis_sel, lean;
		sample_t s;
		kind = $urandom_range(0, 99);
		if (kind < 45) begin
			// Device held still in one of the four orientations.
			n = $urandom_range(2, 18);
			axis_sel = $urandom_range(0, 3);
			mag = $urandom_range(1800, 3000);
			lean = $urandom_range(0, 1200);
			for (int i = 0; i < n; i++) begin
				t_now += $urandom_range(2000, 20000);
				case (axis_sel)
					0: add_sample(jitter(lean - 600, 80), jitter(mag, 80), jitter(0, 900));
					1: add_sample(jitter(-mag, 80), jitter(lean - 600, 80), jitter(0, 900));
					2: add_sample(jitter(lean - 600, 80), jitter(-mag, 80), jitter(0, 900));
					default: add_sample(jitter(mag, 80), jitter(lean - 600, 80), jitter(0, 900));
				endcase
			end
		end else if (kind < 75) begin
			// Shake burst of large back-and-forth swings.
			n = $urandom_range(2, 7);
			for (int i = 0; i < n; i++) begin
				t_now += ($urandom_range(0, 9) == 0) ? $urandom_range(500000, 3000000)
					: $urandom_range(1000, 15000);
				add_sample(jitter(0, 9000), jitter(0, 9000), jitter(0, 9000));
			end
		end else if (kind < 85) begin
			// Lying flat, close to free fall, or barely moving.
			t_now += $urandom_range(1000, 30000);
			add_sample(jitter(0, 300), jitter(0, 300), jitter(($urandom_range(0, 1)) ? 2510 : 0, 300));
		end else begin
			// Full-range noise, sometimes with an arbitrary timestamp.
			s.x = SampleBits'($urandom());
			s.y = SampleBits'($urandom());
			s.z = SampleBits'($urandom());
			s.t = ($urandom_range(0, 3) == 0) ? TimeBits'({$urandom(), $urandom()}) : t_now;
			t_now += $urandom_range(1, 40000);
			pending_samples.push_back(s);
		end
	endtask

	initial begin
		alpha_q12 = 901;
		orient_min = 1485;
		stable_cnt = 5;
		jerk_lo = 1280;
		jerk_hi = 2304;
		grav_band = 717;
		cooldown = 2000000;
		primed = 1'b0;
		for (int i = 0; i < 3; i++) begin
			smooth[i] = 0;
			prev_raw[i] = 0;
		end
		candidate = ClassNone;
		applied = ClassNone;
		run_len = 0;
		motion_score = 0;
		last_shake_t = '0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part with reset settings: the seeding sample, a class that
		// becomes stable, field extremes, a shake inside the first cooldown,
		// one after it, and each of the other orientations in turn.
		for (int i = 0; i < 5; i++) begin
			add_sample(0, 2510, 0);
			t_now += 8000;
		end
		add_sample(32767, -32768, 32767);
		t_now += 100;
		add_sample(-32768, 32767, -32768);
		t_now = 48'd2100000;
		add_sample(0, 0, 0);
		t_now += 8000;
		add_sample(0, 0, 0);
		add_sample(0, 0, 2510);
		for (int i = 0; i < 5; i++) begin
			t_now += 8000;
			add_sample(2510, 0, 0);
		end
		for (int i = 0; i < 5; i++) begin
			t_now += 8000;
			add_sample(-2510, 0, 0);
		end
		for (int i = 0; i < 5; i++) begin
			t_now += 8000;
			add_sample(0, -2510, 0);
		end
		wait_idle();

		for (int p = 0; p < RandomPhases; p++) begin
			case (p)
				0: write_all(24'd4095, 24'd0, 24'd1, 24'd0, 24'd0, 24'd0, 24'd0);
				1: write_all(24'd0, 24'd32767, 24'd15, 24'd65535, 24'd65535, 24'd32767,
					24'd16777215);
				2: write_all(24'd901, 24'd1485, 24'd0, 24'd1280, 24'd2304, 24'd3000, 24'd5000);
				3: begin
					// Timestamps wrap around the top of the counter in this phase.
					t_now = {TimeBits{1'b1}} - 48'd400000;
					write_all(24'd2048, 24'd1000, 24'd3, 24'd900, 24'd2000, 24'd500, 24'd20000);
				end
				default: write_all(24'($urandom()),
					24'($urandom_range(500, 2500) | ($urandom() & 24'hFF8000)),
					24'($urandom()), 24'($urandom_range(0, 3000)), 24'($urandom_range(1000, 5000)),
					24'($urandom_range(0, 3000)), 24'($urandom_range(0, 100000)));
			endcase
			while (pending_samples.size() < PhaseSamples) add_random_sequence();
			wait_idle();
		end

		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- accel_orientation_shake_detector_unit.f -----
rtl/core/aosd_pkg.sv
rtl/core/aosd_datapath.sv
rtl/core/aosd_ctrl.sv
rtl/core/accel_orientation_shake_detector_unit.sv
dv/accel_orientation_shake_detector_unit_tb.sv
